// ===== rtl/nce_pkg.sv =====
package nce_pkg;

    localparam int NUM_FUNCS_DEF   = 64;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int ID_W   = 6;
    localparam int TS_W   = 32;
    localparam int TOT_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [TS_W-1:0] MAX_TICK = {TS_W{1'b1}};

    // tdata is func_id / result_id, then the 32-bit time, padded to bytes
    localparam int DATA_W = ((ID_W + TS_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef struct packed {
        logic clr_en;   // clear one totals entry
        logic load;     // event beat accepted, capture and read memories
        logic commit;   // apply the event and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last; // clearing pass at its last entry
        logic out_busy; // result register full and not taken
    } dp_status_t;

endpackage

// ===== rtl/nested_call_exclusive_time_top.sv =====
// Nested call exclusive-time profiler.
//
// Input stream (s_*): one beat per event. s_tuser carries the event kind
// (0 function start, 1 function end); s_tdata carries func_id and the event
// timestamp. Output stream (m_*): one beat per event with the echoed id,
// the id's saturating exclusive total after the event, and a status in
// m_tuser (0 ok, 1 end on empty stack ignored, 2 start on full stack ignored).
//
// Timing: an event is taken in S_IDLE, where the stack frame below the top and
// the totals entry are read into registers; in S_EXEC they are written back and
// the result is loaded into the output register on m_*. The separate accept and
// execute states are set by the registered read of the stack and totals memories.
//
// Reset: aresetn (synchronous, active low) empties the call stack and then
// runs a clearing pass over all NUM_FUNCS totals entries; s_tready
// stays low during that pass.
// Stall: the result register holds a beat until m_tready; the next event may
// be accepted meanwhile, but its result waits until the register frees.
module nested_call_exclusive_time_top #(
    parameter int NUM_FUNCS   = nce_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = nce_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nce_pkg::DATA_W-1:0]  s_tdata,   // func_id[5:0], timestamp[37:6], pad
    input  logic                        s_tuser,   // opcode[0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nce_pkg::DATA_W-1:0]  m_tdata,   // result_id[5:0], total_time[37:6], pad
    output logic [nce_pkg::STAT_W-1:0]  m_tuser    // status[1:0]
);

    localparam int ID_W  = nce_pkg::ID_W;
    localparam int TS_W  = nce_pkg::TS_W;
    localparam int PAD_W = nce_pkg::DATA_W - ID_W - TS_W;

    nce_pkg::ctrl_cmd_t  cmd;
    nce_pkg::dp_status_t dp_stat;

    logic [ID_W-1:0]          out_id;
    logic [nce_pkg::TOT_W-1:0] out_total;

    nce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    nce_dp #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .dp_stat    (dp_stat),
        .in_op      (s_tuser),
        .in_id      (s_tdata[ID_W-1:0]),
        .in_ts      (s_tdata[ID_W+TS_W-1:ID_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_id     (out_id),
        .out_total  (out_total),
        .out_status (m_tuser)
    );

    // pad bits of the output beat are zero
    assign m_tdata = {{PAD_W{1'b0}}, out_total, out_id};

endmodule

// ===== rtl/nce_ctrl.sv =====
module nce_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  nce_pkg::dp_status_t dp_stat,
    output nce_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (dp_stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the previous result has been taken
                if (!dp_stat.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/nce_dp.sv =====
module nce_dp #(
    parameter int NUM_FUNCS   = nce_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = nce_pkg::STACK_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  nce_pkg::ctrl_cmd_t         cmd,
    output nce_pkg::dp_status_t        dp_stat,
    input  logic                       in_op,
    input  logic [nce_pkg::ID_W-1:0]   in_id,
    input  logic [nce_pkg::TS_W-1:0]   in_ts,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [nce_pkg::ID_W-1:0]   out_id,
    output logic [nce_pkg::TOT_W-1:0]  out_total,
    output logic [nce_pkg::STAT_W-1:0] out_status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int TAW   = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int TS_W  = nce_pkg::TS_W;
    localparam int TOT_W = nce_pkg::TOT_W;
    localparam int FRM_W = 2 * TS_W;

    // frames below the top of stack; the top frame lives in registers
    logic [FRM_W-1:0] stk_mem [STACK_DEPTH];
    logic [TOT_W-1:0] tot_mem [NUM_FUNCS];

    logic [CNT_W-1:0] cnt_reg;
    logic [TS_W-1:0]  top_start_reg;
    logic [TS_W-1:0]  top_run_reg;
    logic [TAW-1:0]   clr_reg;

    logic             op_reg;
    logic [nce_pkg::ID_W-1:0] id_reg;
    logic [TS_W-1:0]  ts_reg;
    logic             id_ok_reg;
    logic [TS_W-1:0]  pause_run_reg;
    logic [TS_W-1:0]  credit_reg;
    logic [FRM_W-1:0] stk_rd_reg;
    logic [TOT_W-1:0] tot_rd_reg;

    // ---- accept-cycle arithmetic on the top frame
    logic [TAW+nce_pkg::ID_W-1:0] id_ext;
    logic [TAW-1:0]   id_addr;
    logic             id_ok;
    logic             ts_ge;
    logic [TS_W-1:0]  elapsed;
    logic [TS_W:0]    run_sum;
    logic [TS_W-1:0]  pause_run;
    logic [TS_W-1:0]  credit;
    logic [SAW-1:0]   below_addr;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;

    assign id_ext     = (TAW + nce_pkg::ID_W)'(in_id);
    assign id_addr    = id_ext[TAW-1:0];
    assign id_ok      = 32'(in_id) < 32'(NUM_FUNCS);
    assign ts_ge      = in_ts >= top_start_reg;
    assign elapsed    = in_ts - top_start_reg;
    assign run_sum    = {1'b0, top_run_reg} + {1'b0, elapsed};
    assign pause_run  = !ts_ge ? top_run_reg :
                        (run_sum[TS_W] ? nce_pkg::MAX_TICK : run_sum[TS_W-1:0]);
    // inclusive interval is elapsed + 1
    assign credit     = !ts_ge ? top_run_reg :
                        ((run_sum >= {1'b0, nce_pkg::MAX_TICK}) ? nce_pkg::MAX_TICK :
                         run_sum[TS_W-1:0] + TS_W'(1));
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign cnt_m2     = cnt_reg - CNT_W'(2);
    assign below_addr = cnt_m2[SAW-1:0];

    // ---- execute-cycle decisions
    logic             is_empty;
    logic             is_full;
    logic             do_pop;
    logic             do_push;
    logic [TOT_W:0]   tot_sum;
    logic [TOT_W-1:0] new_total;
    logic [TS_W-1:0]  resume;
    logic [TAW+nce_pkg::ID_W-1:0] idr_ext;
    logic [TAW-1:0]   idr_addr;
    logic [TOT_W-1:0] total_shown;
    nce_pkg::status_t status_val;

    assign is_empty  = cnt_reg == '0;
    assign is_full   = cnt_reg == CNT_W'(STACK_DEPTH);
    assign do_pop    = (op_reg == nce_pkg::OP_END) && !is_empty;
    assign do_push   = (op_reg == nce_pkg::OP_START) && !is_full;
    assign tot_sum   = {1'b0, tot_rd_reg} + {1'b0, credit_reg};
    assign new_total = tot_sum[TOT_W] ? nce_pkg::MAX_TICK : tot_sum[TOT_W-1:0];
    assign resume    = (ts_reg == nce_pkg::MAX_TICK) ? nce_pkg::MAX_TICK :
                       ts_reg + TS_W'(1);
    assign idr_ext   = (TAW + nce_pkg::ID_W)'(id_reg);
    assign idr_addr  = idr_ext[TAW-1:0];
    assign total_shown = !id_ok_reg ? '0 : (do_pop ? new_total : tot_rd_reg);

    always_comb begin
        status_val = nce_pkg::ST_OK;
        if ((op_reg == nce_pkg::OP_END) && is_empty) begin
            status_val = nce_pkg::ST_EMPTY;
        end else if ((op_reg == nce_pkg::OP_START) && is_full) begin
            status_val = nce_pkg::ST_FULL;
        end
    end

    assign dp_stat.clr_last = clr_reg == TAW'(NUM_FUNCS - 1);
    assign dp_stat.out_busy = m_tvalid && !m_tready;

    // ---- memories
    always_ff @(posedge aclk) begin
        if (cmd.clr_en) begin
            tot_mem[clr_reg] <= '0;
        end else if (cmd.commit && do_pop && id_ok_reg) begin
            tot_mem[idr_addr] <= new_total;
        end
        if (cmd.load) begin
            tot_rd_reg <= tot_mem[id_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && do_push && !is_empty) begin
            stk_mem[cnt_m1[SAW-1:0]] <= {pause_run_reg, top_start_reg};
        end
        if (cmd.load) begin
            stk_rd_reg <= stk_mem[below_addr];
        end
    end

    // ---- event capture and top frame
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= in_op;
            id_reg        <= in_id;
            ts_reg        <= in_ts;
            id_ok_reg     <= id_ok;
            pause_run_reg <= pause_run;
            credit_reg    <= credit;
        end
        if (cmd.commit) begin
            if (do_push) begin
                top_start_reg <= ts_reg;
                top_run_reg   <= '0;
            end else if (do_pop && (cnt_reg != CNT_W'(1))) begin
                top_start_reg <= resume;
                top_run_reg   <= stk_rd_reg[FRM_W-1:TS_W];
            end
            out_id     <= id_reg;
            out_total  <= total_shown;
            out_status <= status_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            clr_reg  <= '0;
            m_tvalid <= 1'b0;
        end else begin
            if (cmd.clr_en) begin
                clr_reg <= clr_reg + TAW'(1);
            end
            if (cmd.commit) begin
                if (do_push) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end else if (do_pop) begin
                    cnt_reg <= cnt_m1;
                end
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

endmodule
